FILE: sv/ljce_pkg.sv
// ljce_pkg: shared constants for the lennard-jones cluster energy block
// no dependencies
`default_nettype none
package ljce_pkg;
    localparam int MAX_ATOMS_DEF       = 64;
    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int COORD_W             = 32;
    localparam int ENERGY_W            = 64;
    localparam int COUNT_OUT_W         = 7;
    localparam int R2_W                = 66;
    localparam int REM_W               = 67;
    localparam int DIFF_W              = 33;
    localparam logic [ENERGY_W-1:0] ENERGY_SAT = {1'b0, {(ENERGY_W-1){1'b1}}};
endpackage
`default_nettype wire

FILE: sv/lennard_jones_cluster_energy_top.sv
// lennard_jones_cluster_energy_top: cluster energy sum over all atom pairs
// depends on ljce_pkg
//
// Atoms are written into three coordinate memories as they arrive while there is room.
// Each atom stored is then paired with every atom stored before it: one synchronous memory
// read, three squares, a restoring divide of one quotient bit per cycle for 1/r^2, and
// three Q32.32 products of four 32x32 partial products each. A close pair skips the
// divide and products and saturates the result; an atom arriving with atoms stored keeps
// the input stalled until all of its pairs are done. The result for a cluster is held in
// an output register, and later atoms are taken while it waits; a closing atom waits for
// it to go.
`default_nettype none
module lennard_jones_cluster_energy_top #(
    parameter int MAX_ATOMS       = ljce_pkg::MAX_ATOMS_DEF,
    parameter int COORD_FRAC_BITS = ljce_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire  logic                                   clk,
    input  wire  logic                                   rst_n,
    input  wire  logic                                   in_valid,
    output logic                                         in_stall,
    input  wire  logic signed [ljce_pkg::COORD_W-1:0]    coord_x,
    input  wire  logic signed [ljce_pkg::COORD_W-1:0]    coord_y,
    input  wire  logic signed [ljce_pkg::COORD_W-1:0]    coord_z,
    input  wire  logic                                   last_atom,
    output logic                                         out_valid,
    input  wire  logic                                   out_stall,
    output logic signed [ljce_pkg::ENERGY_W-1:0]         energy,
    output logic        [ljce_pkg::COUNT_OUT_W-1:0]      atom_count,
    output logic                                         saturated,
    output logic                                         too_many_atoms
);
    localparam int IDX_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNT_W = $clog2(MAX_ATOMS + 1);
    localparam int TOP   = 32 + 2 * COORD_FRAC_BITS;
    localparam int BIT_W = $clog2(TOP + 1);
    localparam int CW    = ljce_pkg::COORD_W;
    localparam int EW    = ljce_pkg::ENERGY_W;
    localparam int RW    = ljce_pkg::R2_W;
    localparam int MW    = ljce_pkg::REM_W;
    localparam int DW    = ljce_pkg::DIFF_W;
    localparam logic [RW-1:0]    THR     = RW'(1) << (2 * COORD_FRAC_BITS - 5);
    localparam logic [BIT_W-1:0] TOP_B   = BIT_W'(TOP);
    localparam logic [CNT_W-1:0] MAX_C   = CNT_W'(MAX_ATOMS);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_SQ, S_CHK, S_DIV, S_MUL, S_ACC, S_FIN} state_t;

    logic [CW-1:0] mem_x [MAX_ATOMS];
    logic [CW-1:0] mem_y [MAX_ATOMS];
    logic [CW-1:0] mem_z [MAX_ATOMS];
    logic [CW-1:0] rd_x_reg, rd_y_reg, rd_z_reg;

    state_t            state_reg;
    logic [CW-1:0]     cur_x_reg, cur_y_reg, cur_z_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  count_reg, limit_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [1:0]        k_reg;
    logic [1:0]        part_reg;
    logic [RW-1:0]     r2_reg;
    logic [MW-1:0]     rem_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic [EW-1:0]     u_reg, u2_reg, u3_reg, u6_reg, acc_reg;
    logic signed [EW-1:0] sum_reg;
    logic              ovf_reg, drop_reg;
    logic              out_valid_reg;
    logic [EW-1:0]     energy_reg;
    logic [ljce_pkg::COUNT_OUT_W-1:0] count_out_reg;
    logic              sat_reg, tma_reg;

    logic              accept;
    logic              wr_en;
    logic signed [DW-1:0] d_sel;
    logic [DW-1:0]     mag;
    logic [63:0]       sq;
    logic [MW-1:0]     rem_sh;
    logic              q_bit;
    logic [EW-1:0]     op_a, op_b, pp_sh;
    logic [31:0]       ha, hb;
    logic [63:0]       pp;
    logic [EW-1:0]     acc_new;
    logic [EW-1:0]     dval;
    logic [EW-1:0]     term;
    logic [EW:0]       sum_ext;
    logic              term_ok, sum_ok;
    logic [IDX_W-1:0]  idx_next;
    logic              pair_last;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign wr_en    = accept && (count_reg < MAX_C);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[count_reg[IDX_W-1:0]] <= coord_x;
            mem_y[count_reg[IDX_W-1:0]] <= coord_y;
            mem_z[count_reg[IDX_W-1:0]] <= coord_z;
        end
        rd_x_reg <= mem_x[idx_reg];
        rd_y_reg <= mem_y[idx_reg];
        rd_z_reg <= mem_z[idx_reg];
    end

    always_comb
    begin
        case (k_reg)
            2'd0:    d_sel = $signed({cur_x_reg[CW-1], cur_x_reg})
                             - $signed({rd_x_reg[CW-1], rd_x_reg});
            2'd1:    d_sel = $signed({cur_y_reg[CW-1], cur_y_reg})
                             - $signed({rd_y_reg[CW-1], rd_y_reg});
            default: d_sel = $signed({cur_z_reg[CW-1], cur_z_reg})
                             - $signed({rd_z_reg[CW-1], rd_z_reg});
        endcase
        mag = d_sel[DW-1] ? DW'(-d_sel) : DW'(d_sel);
        sq  = 64'(mag) * 64'(mag);

        rem_sh = {rem_reg[MW-2:0], (bit_reg == TOP_B)};
        q_bit  = (rem_sh >= {1'b0, r2_reg});

        case (k_reg)
            2'd0:    begin op_a = u_reg;  op_b = u_reg; end
            2'd1:    begin op_a = u2_reg; op_b = u_reg; end
            default: begin op_a = u3_reg; op_b = u3_reg; end
        endcase
        case (part_reg)
            2'd0:    begin ha = op_a[63:32]; hb = op_b[63:32]; end
            2'd1:    begin ha = op_a[63:32]; hb = op_b[31:0];  end
            2'd2:    begin ha = op_a[31:0];  hb = op_b[63:32]; end
            default: begin ha = op_a[31:0];  hb = op_b[31:0];  end
        endcase
        pp = ha * hb;
        case (part_reg)
            2'd0:    pp_sh = {pp[31:0], 32'd0};
            2'd3:    pp_sh = {32'd0, pp[63:32]};
            default: pp_sh = pp;
        endcase
        acc_new = acc_reg + pp_sh;

        dval    = u6_reg - u3_reg;
        term_ok = (dval[63] == dval[62]) && (dval[62] == dval[61]);
        term    = {dval[61:0], 2'b00};
        sum_ext = {sum_reg[EW-1], sum_reg} + {term[EW-1], term};
        sum_ok  = (sum_ext[EW] == sum_ext[EW-1]);

        idx_next  = idx_reg + 1'b1;
        pair_last = (CNT_W'(idx_reg) + 1'b1) == limit_reg;
    end

    assign out_valid      = out_valid_reg;
    assign energy         = energy_reg;
    assign atom_count     = count_out_reg;
    assign saturated      = sat_reg;
    assign too_many_atoms = tma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            k_reg         <= '0;
            part_reg      <= '0;
            last_reg      <= 1'b0;
            limit_reg     <= '0;
            bit_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !(state_reg == S_FIN && last_reg))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cur_x_reg <= coord_x;
                        cur_y_reg <= coord_y;
                        cur_z_reg <= coord_z;
                        last_reg  <= last_atom;
                        idx_reg   <= '0;
                        if (count_reg < MAX_C)
                        begin
                            limit_reg <= count_reg;
                            count_reg <= count_reg + 1'b1;
                            state_reg <= (count_reg == '0) ? S_FIN : S_READ;
                        end
                        else
                        begin
                            drop_reg  <= 1'b1;
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_READ:
                begin
                    k_reg     <= '0;
                    r2_reg    <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    r2_reg <= r2_reg + RW'(sq);
                    if (k_reg == 2'd2)
                    begin
                        state_reg <= S_CHK;
                    end
                    k_reg <= k_reg + 1'b1;
                end
                S_CHK:
                begin
                    if (r2_reg <= THR)
                    begin
                        ovf_reg   <= 1'b1;
                        idx_reg   <= idx_next;
                        state_reg <= pair_last ? S_FIN : S_READ;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        u_reg     <= '0;
                        bit_reg   <= TOP_B;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= q_bit ? rem_sh - {1'b0, r2_reg} : rem_sh;
                    u_reg   <= {u_reg[EW-2:0], q_bit};
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == '0)
                    begin
                        k_reg     <= '0;
                        part_reg  <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    part_reg <= part_reg + 1'b1;
                    if (part_reg == 2'd3)
                    begin
                        acc_reg <= '0;
                        k_reg   <= k_reg + 1'b1;
                        case (k_reg)
                            2'd0:    u2_reg <= acc_new;
                            2'd1:    u3_reg <= acc_new;
                            default:
                            begin
                                u6_reg    <= acc_new;
                                state_reg <= S_ACC;
                            end
                        endcase
                    end
                    else
                    begin
                        acc_reg <= acc_new;
                    end
                end
                S_ACC:
                begin
                    if (term_ok && sum_ok)
                    begin
                        sum_reg <= sum_ext[EW-1:0];
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                    idx_reg   <= idx_next;
                    state_reg <= pair_last ? S_FIN : S_READ;
                end
                S_FIN:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        energy_reg    <= ovf_reg ? ljce_pkg::ENERGY_SAT : sum_reg;
                        count_out_reg <= ljce_pkg::COUNT_OUT_W'(count_reg);
                        sat_reg       <= ovf_reg;
                        tma_reg       <= drop_reg;
                        count_reg     <= '0;
                        sum_reg       <= '0;
                        ovf_reg       <= 1'b0;
                        drop_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: dv/tb.sv
// tb: self-checking testbench for lennard_jones_cluster_energy_top
// atom clusters go in through the input channel and each cluster energy is predicted and checked
// depends on ljce_pkg and lennard_jones_cluster_energy_top
`timescale 1ns / 1ps
module tb;
    localparam int  F          = ljce_pkg::COORD_FRAC_BITS_DEF;
    localparam int  N_ATOMS    = ljce_pkg::MAX_ATOMS_DEF;
    localparam int  LIMIT      = 4000000;
    localparam int  PHASE_LEN  = 420;
    localparam int  HOLD_LEN   = 4000;

    typedef struct {
        logic signed [ljce_pkg::COORD_W-1:0] x;
        logic signed [ljce_pkg::COORD_W-1:0] y;
        logic signed [ljce_pkg::COORD_W-1:0] z;
        logic                                last;
    } atom_t;

    typedef struct {
        logic signed [ljce_pkg::ENERGY_W-1:0]  e;
        logic [ljce_pkg::COUNT_OUT_W-1:0]      n;
        logic                                  sat;
        logic                                  drop;
    } cluster_res_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [ljce_pkg::COORD_W-1:0] coord_x;
    logic signed [ljce_pkg::COORD_W-1:0] coord_y;
    logic signed [ljce_pkg::COORD_W-1:0] coord_z;
    logic last_atom;
    logic out_valid;
    logic out_stall;
    logic signed [ljce_pkg::ENERGY_W-1:0] energy;
    logic [ljce_pkg::COUNT_OUT_W-1:0] atom_count;
    logic saturated;
    logic too_many_atoms;

    atom_t        atom_q[$];
    cluster_res_t energy_q[$];
    int           errors = 0;
    int           atoms_sent = 0;
    int           clusters_checked = 0;
    int           cycles = 0;
    int           hold_left;
    bit           hold_done;

    // predictor state
    logic signed [ljce_pkg::COORD_W-1:0] px[N_ATOMS];
    logic signed [ljce_pkg::COORD_W-1:0] py[N_ATOMS];
    logic signed [ljce_pkg::COORD_W-1:0] pz[N_ATOMS];
    int                        p_loaded = 0;
    logic signed [63:0]        p_sum = '0;
    bit                        p_ovf = 0;
    bit                        p_drop = 0;

    lennard_jones_cluster_energy_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .last_atom(last_atom),
        .out_valid(out_valid), .out_stall(out_stall),
        .energy(energy), .atom_count(atom_count),
        .saturated(saturated), .too_many_atoms(too_many_atoms)
    );

    function automatic logic [127:0] sq_gap(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        logic [127:0] m;
        d = longint'(a) - longint'(b);
        m = (d < 0) ? 128'(-d) : 128'(d);
        return m * m;
    endfunction

    function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[95:32];
    endfunction

    function automatic void add_pair_energy(int i, atom_t a);
        logic [127:0] r2;
        logic [127:0] q;
        logic [63:0]  u, u2, u3, u6;
        longint       diff;
        logic [64:0]  s;
        r2 = sq_gap(a.x, px[i]) + sq_gap(a.y, py[i]) + sq_gap(a.z, pz[i]);
        if (r2 <= (128'(1) << (2*F-5))) begin
            p_ovf = 1;
            return;
        end
        q  = (128'(1) << (32+2*F)) / r2;
        u  = q[63:0];
        u2 = mul_q32(u, u);
        u3 = mul_q32(u2, u);
        u6 = mul_q32(u3, u3);
        diff = longint'(u6) - longint'(u3);
        if (diff > (64'sh7FFF_FFFF_FFFF_FFFF / 4) || diff < -(64'sh2000_0000_0000_0000)) begin
            p_ovf = 1;
            return;
        end
        s = {p_sum[63], p_sum} + {diff[63], diff * 4};
        if (s[64] != s[63])
            p_ovf = 1;
        else
            p_sum = s[63:0];
    endfunction

    function automatic void take_atom(atom_t a);
        cluster_res_t r;
        if (p_loaded < N_ATOMS) begin
            for (int i = 0; i < p_loaded; i++)
                add_pair_energy(i, a);
            px[p_loaded] = a.x;
            py[p_loaded] = a.y;
            pz[p_loaded] = a.z;
            p_loaded++;
        end else begin
            p_drop = 1;
        end
        if (a.last) begin
            r.e    = p_ovf ? ljce_pkg::ENERGY_SAT : p_sum;
            r.n    = p_loaded[ljce_pkg::COUNT_OUT_W-1:0];
            r.sat  = p_ovf;
            r.drop = p_drop;
            energy_q = {energy_q, r};
            p_loaded = 0;
            p_sum    = 0;
            p_ovf    = 0;
            p_drop   = 0;
        end
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h (cluster %0d)", what, got, want,
                 clusters_checked);
        errors++;
    endtask

    task automatic push_atom(int x, int y, int z, bit last);
        atom_t a;
        a.x = x;
        a.y = y;
        a.z = z;
        a.last = last;
        atom_q = {atom_q, a};
    endtask

    task automatic push_cluster(int n);
        int cx, cy, cz, kind;
        int ax, ay, az;
        kind = $urandom_range(0, 9);
        cx = $urandom;
        cy = $urandom;
        cz = $urandom;
        for (int i = 0; i < n; i++) begin
            if (kind == 0) begin
                ax = $urandom;
                ay = $urandom;
                az = $urandom;
            end else if (i > 0 && $urandom_range(0, 19) == 0) begin
                ax = atom_q[$].x;
                ay = atom_q[$].y;
                az = atom_q[$].z;
            end else if (kind == 1) begin
                ax = cx + int'($urandom_range(0, 32768)) - 16384;
                ay = cy + int'($urandom_range(0, 32768)) - 16384;
                az = cz + int'($urandom_range(0, 32768)) - 16384;
            end else begin
                ax = cx + int'($urandom_range(0, 327680)) - 163840;
                ay = cy + int'($urandom_range(0, 327680)) - 163840;
                az = cz + int'($urandom_range(0, 327680)) - 163840;
            end
            push_atom(ax, ay, az, i == n - 1);
        end
    endtask

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // driver
    always @(posedge clk or negedge rst_n) begin
        atom_t a;
        int idle;
        if (!rst_n) begin
            in_valid  <= 0;
            coord_x   <= '0;
            coord_y   <= '0;
            coord_z   <= '0;
            last_atom <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                a.x = coord_x;
                a.y = coord_y;
                a.z = coord_z;
                a.last = last_atom;
                take_atom(a);
                atoms_sent++;
            end
            if (!in_valid || !in_stall) begin
                idle = (atoms_sent < PHASE_LEN) ? 25 : (atoms_sent < 2*PHASE_LEN) ? 46 : 0;
                if (atom_q.size() > 0 && $urandom_range(0, 99) >= idle) begin
                    a = atom_q.pop_front();
                    in_valid  <= 1;
                    coord_x   <= a.x;
                    coord_y   <= a.y;
                    coord_z   <= a.z;
                    last_atom <= a.last;
                end else begin
                    in_valid <= 0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 0;
        end else if (!hold_done && atoms_sent >= 300) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        cluster_res_t r;
        int idle;
        if (!rst_n) begin
            out_stall <= 1;
        end else begin
            if (out_valid && !out_stall) begin
                if (energy_q.size() == 0) begin
                    report("result with no cluster pending", energy, 64'd0);
                end else begin
                    r = energy_q.pop_front();
                    if (energy !== r.e)
                        report("energy", energy, r.e);
                    if (atom_count !== r.n)
                        report("atom_count", 64'(atom_count), 64'(r.n));
                    if (saturated !== r.sat)
                        report("saturated", 64'(saturated), 64'(r.sat));
                    if (too_many_atoms !== r.drop)
                        report("too_many_atoms", 64'(too_many_atoms), 64'(r.drop));
                end
                clusters_checked++;
            end
            idle = (atoms_sent < PHASE_LEN) ? 46 : (atoms_sent < 2*PHASE_LEN) ? 25 : 0;
            out_stall <= (hold_left > 1) || ($urandom_range(0, 99) < idle);
        end
    end

    initial begin
        int total;

        // single atom, extremes, coincident, unit distance, close-pair boundary
        push_atom(5, -7, 9, 1);
        push_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        push_atom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        push_atom(0, 0, 0, 0);
        push_atom(0, 0, 0, 1);
        push_atom(-65536, 3, 0, 0);
        push_atom(0, 3, 0, 1);
        push_atom(100, 0, 0, 0);
        push_atom(100 + 11585, 0, 0, 1);
        push_atom(100, 0, 0, 0);
        push_atom(100 + 11586, 0, 0, 1);
        // two large terms whose sum leaves the range
        push_atom(0, 0, 0, 0);
        push_atom(12452, 0, 0, 0);
        push_atom(24904, 0, 0, 1);
        push_atom(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000, 0);
        push_atom(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1);
        // store overflow: 66 atoms on a wide grid, last two dropped
        for (int i = 0; i < N_ATOMS + 2; i++)
            push_atom((i % 4) * 131072, ((i / 4) % 4) * 131072, (i / 16) * 131072,
                      i == N_ATOMS + 1);

        total = atom_q.size();
        while (total < 1250) begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            push_cluster(n);
            total += n;
        end

        rst_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;

        wait (atom_q.size() == 0 && !in_valid);
        wait (energy_q.size() == 0);
        repeat (300) @(posedge clk);
        if (energy_q.size() != 0)
            $display("%0d cluster results never arrived", energy_q.size());
        $display("%0d atoms sent, %0d cluster energies checked", atoms_sent, clusters_checked);
        $display("covered close pairs, overflow, full store and long output hold-off");
        if (errors == 0 && energy_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
